/* rtl/core/wpme_pkg.sv */
// ----------------------------------------------------------------------------
// wpme_pkg
// Shared widths, constants, the CORDIC arctangent table and the CORDIC
// vector type for the weighted pose mean estimator.
// ----------------------------------------------------------------------------
package wpme_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // datapath widths
    localparam int CW         = 46;   // cordic x/y
    localparam int ZW         = 24;   // cordic angle, 2^-16 rad
    localparam int SUM_XY_W   = 58;
    localparam int SUM_TRIG_W = 42;
    localparam int SUM_WT_W   = 26;
    localparam int PROD_W     = 50;   // 17 x 33 signed product
    localparam int DIV_CNT_W  = 6;

    localparam logic signed [ZW-1:0] PI_Q16      = 24'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 24'sd102944;
    localparam logic signed [CW-1:0] GAIN_Q30    = 46'sd652032874;
    localparam logic signed [CW-1:0] NORM_LIMIT  = 46'sd1099511627776;
    localparam logic signed [15:0]   HEAD_MAX    = 16'sd25736;
    localparam logic signed [15:0]   TRIG_MAX    = 16'sd16384;

    typedef struct packed {
        logic                 vec;   // 1: vectoring, 0: rotation
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_vec_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:    a = 24'sd51472;
            5'd1:    a = 24'sd30386;
            5'd2:    a = 24'sd16055;
            5'd3:    a = 24'sd8150;
            5'd4:    a = 24'sd4091;
            5'd5:    a = 24'sd2047;
            5'd6:    a = 24'sd1024;
            5'd7:    a = 24'sd512;
            5'd8:    a = 24'sd256;
            5'd9:    a = 24'sd128;
            5'd10:   a = 24'sd64;
            5'd11:   a = 24'sd32;
            5'd12:   a = 24'sd16;
            5'd13:   a = 24'sd8;
            5'd14:   a = 24'sd4;
            5'd15:   a = 24'sd2;
            5'd16:   a = 24'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/core/weighted_pose_mean_estimator_unit.sv */
// ----------------------------------------------------------------------------
// weighted_pose_mean_estimator_unit
// Weighted mean pose of a particle set: mean x/y by division by the weight
// sum, circular mean heading by CORDIC vectoring of the trig sums.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  s_ (in)   | input     | s_valid / s_ready  | particle x, y, heading, weight, last
//  m_ (out)  | output    | m_valid / m_ready  | mean x, y, heading, zero weight flag
//
//  a particle request runs one rotation pass on the shared cordic, then the
//  weighted accumulation; a last particle adds two divides, a normalize loop
//  and one more vectoring pass
//  s_ready is high only in idle; a finished estimate waits in the output
//  register while the next set is accepted
//  synchronous active-low reset clears the sums and the sequencer
// ----------------------------------------------------------------------------
module weighted_pose_mean_estimator_unit
    import wpme_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_particle_x,
    input  logic signed [31:0] s_particle_y,
    input  logic signed [15:0] s_particle_heading,
    input  logic        [15:0] s_particle_weight,
    input  logic               s_last_particle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_mean_x,
    output logic signed [31:0] m_mean_y,
    output logic signed [15:0] m_mean_heading,
    output logic               m_zero_weight_error
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROT_GO, ST_ROT_WAIT, ST_TRIG, ST_MAC, ST_CHECK,
        ST_DIVX_GO, ST_DIVX_WAIT, ST_DIVY_GO, ST_DIVY_WAIT,
        ST_NORM, ST_QUAD, ST_VEC_GO, ST_VEC_WAIT, ST_OUT
    } state_t;

    state_t state_reg;

    // particle holding registers
    logic signed [31:0] px_reg, py_reg;
    logic        [15:0] w_reg;
    logic               last_reg;
    logic               flip_reg;
    logic signed [15:0] c_reg, s_reg;

    // accumulators
    logic signed [SUM_XY_W-1:0]   sum_x_reg, sum_y_reg;
    logic signed [SUM_TRIG_W-1:0] sum_c_reg, sum_s_reg;
    logic        [SUM_WT_W-1:0]   sum_w_reg;

    logic        [2:0]        mac_cnt_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // estimate stage
    logic signed [CW-1:0] vx_reg, vy_reg;
    logic [SUM_XY_W-1:0]  div_num_reg;
    logic                 div_neg_reg;
    logic signed [31:0]   mx_reg, my_reg;
    logic signed [15:0]   mh_reg;
    logic                 err_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_mean_x_reg, m_mean_y_reg;
    logic signed [15:0] m_mean_heading_reg;
    logic               m_err_reg;

    cordic_vec_t cin_reg;
    cordic_vec_t cres;
    logic        cordic_done;
    logic        div_done;
    logic [SUM_XY_W-1:0] div_quo;

    // combinational helpers
    logic signed [ZW-1:0]   hz;
    logic signed [32:0]     mul_op;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [CW-1:0]   rx, ry, ax, ay, amax;
    logic signed [31:0]     div_sat;
    logic signed [ZW-4:0]   hd;
    logic signed [15:0]     heading_q13;

    function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0]  t;
        logic signed [CW-17:0] r;
        t = v + CW'(32768);
        r = (CW-16)'(t >>> 16);
        if (r > (CW-16)'(TRIG_MAX)) begin
            return TRIG_MAX;
        end else if (r < -(CW-16)'(TRIG_MAX)) begin
            return -TRIG_MAX;
        end
        return 16'(r);
    endfunction

    function automatic logic [SUM_XY_W-1:0] mag58(input logic signed [SUM_XY_W-1:0] v);
        return v[SUM_XY_W-1] ? SUM_XY_W'(-v) : SUM_XY_W'(v);
    endfunction

    always_comb begin
        hz = ZW'(s_particle_heading) <<< 3;

        // shared multiplier operand: x, y, cos, sin in turn
        case (mac_cnt_reg)
            3'd0:    mul_op = 33'(px_reg);
            3'd1:    mul_op = 33'(py_reg);
            3'd2:    mul_op = 33'(c_reg);
            default: mul_op = 33'(s_reg);
        endcase
        prod_next = $signed({1'b0, w_reg}) * mul_op;

        // undo the half-turn fold of the rotation input
        rx = flip_reg ? -cres.x : cres.x;
        ry = flip_reg ? -cres.y : cres.y;

        ax   = vx_reg[CW-1] ? -vx_reg : vx_reg;
        ay   = vy_reg[CW-1] ? -vy_reg : vy_reg;
        amax = (ay > ax) ? ay : ax;

        // truncated magnitude quotient back to a saturated signed mean
        if (div_neg_reg) begin
            div_sat = (div_quo > SUM_XY_W'(64'h8000_0000)) ? 32'sh8000_0000
                                                             : 32'(-div_quo);
        end else begin
            div_sat = (div_quo > SUM_XY_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                             : 32'(div_quo);
        end

        hd = (ZW-3)'((cres.z + ZW'(4)) >>> 3);
        if (hd > (ZW-3)'(HEAD_MAX)) begin
            heading_q13 = HEAD_MAX;
        end else if (hd < -(ZW-3)'(HEAD_MAX)) begin
            heading_q13 = -HEAD_MAX;
        end else begin
            heading_q13 = 16'(hd);
        end
    end

    wpme_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  ((state_reg == ST_ROT_GO) || (state_reg == ST_VEC_GO)),
        .load   (cin_reg),
        .done   (cordic_done),
        .result (cres)
    );

    wpme_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  ((state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO)),
        .num    (div_num_reg),
        .den    (sum_w_reg),
        .done   (div_done),
        .quo    (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            mac_cnt_reg <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_c_reg   <= '0;
            sum_s_reg   <= '0;
            sum_w_reg   <= '0;
        end else begin
            // in ST_OUT the output load below owns the valid flag
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        px_reg   <= s_particle_x;
                        py_reg   <= s_particle_y;
                        w_reg    <= s_particle_weight;
                        last_reg <= s_last_particle;
                        cin_reg.vec <= 1'b0;
                        cin_reg.x   <= GAIN_Q30;
                        cin_reg.y   <= '0;
                        // fold into the cordic's convergence range
                        if (hz > HALF_PI_Q16) begin
                            cin_reg.z <= hz - PI_Q16;
                            flip_reg  <= 1'b1;
                        end else if (hz < -HALF_PI_Q16) begin
                            cin_reg.z <= hz + PI_Q16;
                            flip_reg  <= 1'b1;
                        end else begin
                            cin_reg.z <= hz;
                            flip_reg  <= 1'b0;
                        end
                        state_reg <= ST_ROT_GO;
                    end
                end
                ST_ROT_GO: begin
                    state_reg <= ST_ROT_WAIT;
                end
                ST_ROT_WAIT: begin
                    if (cordic_done) begin
                        state_reg <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    c_reg       <= to_q14(rx);
                    s_reg       <= to_q14(ry);
                    mac_cnt_reg <= '0;
                    state_reg   <= ST_MAC;
                end
                ST_MAC: begin
                    // product of slot n, accumulate slot n-1
                    prod_reg <= prod_next;
                    case (mac_cnt_reg)
                        3'd1:    sum_x_reg <= sum_x_reg + SUM_XY_W'(prod_reg);
                        3'd2:    sum_y_reg <= sum_y_reg + SUM_XY_W'(prod_reg);
                        3'd3:    sum_c_reg <= sum_c_reg + SUM_TRIG_W'(prod_reg);
                        3'd4:    sum_s_reg <= sum_s_reg + SUM_TRIG_W'(prod_reg);
                        default: ;
                    endcase
                    if (mac_cnt_reg == 3'd4) begin
                        sum_w_reg   <= sum_w_reg + SUM_WT_W'(w_reg);
                        mac_cnt_reg <= '0;
                        state_reg   <= last_reg ? ST_CHECK : ST_IDLE;
                    end else begin
                        mac_cnt_reg <= mac_cnt_reg + 1'b1;
                    end
                end
                ST_CHECK: begin
                    if (sum_w_reg == '0) begin
                        mx_reg    <= '0;
                        my_reg    <= '0;
                        mh_reg    <= '0;
                        err_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        err_reg     <= 1'b0;
                        div_num_reg <= mag58(sum_x_reg);
                        div_neg_reg <= sum_x_reg[SUM_XY_W-1];
                        state_reg   <= ST_DIVX_GO;
                    end
                end
                ST_DIVX_GO: begin
                    state_reg <= ST_DIVX_WAIT;
                end
                ST_DIVX_WAIT: begin
                    if (div_done) begin
                        mx_reg      <= div_sat;
                        div_num_reg <= mag58(sum_y_reg);
                        div_neg_reg <= sum_y_reg[SUM_XY_W-1];
                        state_reg   <= ST_DIVY_GO;
                    end
                end
                ST_DIVY_GO: begin
                    state_reg <= ST_DIVY_WAIT;
                end
                ST_DIVY_WAIT: begin
                    if (div_done) begin
                        my_reg    <= div_sat;
                        vx_reg    <= CW'(sum_c_reg);
                        vy_reg    <= CW'(sum_s_reg);
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // scale up to full cordic precision, one doubling a cycle
                    if (vx_reg == '0 && vy_reg == '0) begin
                        mh_reg    <= '0;
                        state_reg <= ST_OUT;
                    end else if (amax < NORM_LIMIT) begin
                        vx_reg <= vx_reg <<< 1;
                        vy_reg <= vy_reg <<< 1;
                    end else begin
                        state_reg <= ST_QUAD;
                    end
                end
                ST_QUAD: begin
                    cin_reg.vec <= 1'b1;
                    if (vx_reg[CW-1]) begin
                        if (!vy_reg[CW-1]) begin
                            cin_reg.x <= vy_reg;
                            cin_reg.y <= -vx_reg;
                            cin_reg.z <= HALF_PI_Q16;
                        end else begin
                            cin_reg.x <= -vy_reg;
                            cin_reg.y <= vx_reg;
                            cin_reg.z <= -HALF_PI_Q16;
                        end
                    end else begin
                        cin_reg.x <= vx_reg;
                        cin_reg.y <= vy_reg;
                        cin_reg.z <= '0;
                    end
                    state_reg <= ST_VEC_GO;
                end
                ST_VEC_GO: begin
                    state_reg <= ST_VEC_WAIT;
                end
                ST_VEC_WAIT: begin
                    if (cordic_done) begin
                        mh_reg    <= heading_q13;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_mean_x_reg       <= mx_reg;
                        m_mean_y_reg       <= my_reg;
                        m_mean_heading_reg <= mh_reg;
                        m_err_reg          <= err_reg;
                        sum_x_reg          <= '0;
                        sum_y_reg          <= '0;
                        sum_c_reg          <= '0;
                        sum_s_reg          <= '0;
                        sum_w_reg          <= '0;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_mean_x            = m_mean_x_reg;
    assign m_mean_y            = m_mean_y_reg;
    assign m_mean_heading      = m_mean_heading_reg;
    assign m_zero_weight_error = m_err_reg;

`ifndef SYNTH
    // one particle at a time through the shared units
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous particle in flight");

    // an empty weight sum reports all zeros
    a_zero_weight_zeros: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_weight_error) |->
            (m_mean_x == 0 && m_mean_y == 0 && m_mean_heading == 0))
        else $error("zero weight estimate carries nonzero fields");

    // heading stays clamped to the half turn
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_mean_heading) <= HEAD_MAX &&
                     $signed(m_mean_heading) >= -HEAD_MAX))
        else $error("mean heading outside clamp range");

    // the sums are empty whenever a new set begins after an estimate
    a_sums_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_ready)) |=>
            (sum_w_reg == '0 && sum_x_reg == '0 && sum_s_reg == '0))
        else $error("sums not cleared after estimate");
`endif

endmodule

/* rtl/core/wpme_cordic.sv */
// ----------------------------------------------------------------------------
// wpme_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module wpme_cordic
    import wpme_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  cordic_vec_t load,
    output logic        done,
    output cordic_vec_t result
);

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    cordic_vec_t      cur_reg;
    cordic_vec_t      cur_next;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] ang;
    logic                 neg_dir;

    always_comb begin
        dx      = cur_reg.x >>> cnt_reg;
        dy      = cur_reg.y >>> cnt_reg;
        ang     = atan_q16(5'(cnt_reg));
        neg_dir = cur_reg.vec ? ($signed(cur_reg.y) > 0) : cur_reg.z[ZW-1];
        cur_next     = cur_reg;
        if (neg_dir) begin
            cur_next.x = cur_reg.x + dy;
            cur_next.y = cur_reg.y - dx;
            cur_next.z = cur_reg.z + ang;
        end else begin
            cur_next.x = cur_reg.x - dy;
            cur_next.y = cur_reg.y + dx;
            cur_next.z = cur_reg.z - ang;
        end
    end

    // dx/dy naming: shifted y feeds x, shifted x feeds y
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cur_reg  <= load;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cur_reg <= cur_next;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = cur_reg;

endmodule

/* rtl/core/wpme_div.sv */
// ----------------------------------------------------------------------------
// wpme_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpme_div
    import wpme_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_XY_W-1:0] num,
    input  logic [SUM_WT_W-1:0] den,
    output logic                done,
    output logic [SUM_XY_W-1:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_XY_W-1:0]  quo_reg;
    logic [SUM_WT_W-1:0]  rem_reg;
    logic [SUM_WT_W-1:0]  den_reg;
    logic [SUM_WT_W:0]    rem_sh;
    logic                 fits;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[SUM_XY_W-1]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[SUM_XY_W-2:0], fits};
                rem_reg <= fits ? SUM_WT_W'(rem_sh - {1'b0, den_reg})
                                : SUM_WT_W'(rem_sh);
                if (cnt_reg == DIV_CNT_W'(SUM_XY_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
